[sv/psq_pkg.sv]
// Shared types and codes for the pair sort priority queue.
`timescale 1ns / 1ps

package psq_pkg;

    // One stored pair; packed so that a plain compare orders word first, doc second
    typedef struct packed {
        logic [63:0] word;
        logic [63:0] doc;
    } pair_t;

    // Operation codes on the action field
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // insert the broadcast pair in order
        logic pull;   // shift every entry one cell toward the head
    } cell_cmd_t;

endpackage

[sv/pair_sort_priority_queue.sv]
// Top level: sorted cell chain priority queue over (word, doc) pairs.
//
//  channel | direction | fields                    | handshake
//  in      | input     | action, word, doc         | in_valid / in_ready
//  out     | output    | status, min_word, min_doc | out_valid / out_ready
//
// One item per cycle: a load or pull updates every cell of the chain in the
// cycle it is accepted, and its result appears in the output register next cycle.
// The chain stays sorted ascending; the smallest pair always sits in cell 0.
// Reset clears all valid bits asynchronously; no clearing pass is needed.
// in_ready is high while the output register is empty or being taken this cycle,
// so an output stall holds the input after one waiting result.
`timescale 1ns / 1ps

module pair_sort_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [63:0] word,
    input  logic [63:0] doc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] min_word,
    output logic [63:0] min_doc
);
    import psq_pkg::*;

    pair_t     new_pair;
    pair_t     cell_pair  [CAPACITY];
    logic      cell_valid [CAPACITY];
    logic      cell_gt    [CAPACITY];
    cell_cmd_t cmd;
    logic      accept;
    logic      full;
    logic      empty;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [63:0] min_word_reg;
    logic [63:0] min_word_next;
    logic [63:0] min_doc_reg;
    logic [63:0] min_doc_next;

    assign new_pair.word = word;
    assign new_pair.doc  = doc;

    // Handshake and chain command
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign empty    = !cell_valid[0];
    assign full     = cell_valid[CAPACITY-1];
    assign cmd.load = accept && (action == ACT_LOAD) && !full;
    assign cmd.pull = accept && (action == ACT_PULL) && !empty;

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        pair_t prev_pair;
        logic  prev_valid;
        logic  prev_gt;
        pair_t next_pair;
        logic  next_valid;

        if (i == 0)
        begin : g_head
            assign prev_pair  = new_pair;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end
        else
        begin : g_body
            assign prev_pair  = cell_pair[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_gt    = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_pair  = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_pair  = cell_pair[i+1];
            assign next_valid = cell_valid[i+1];
        end

        psq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_pair   (new_pair),
            .prev_pair  (prev_pair),
            .prev_valid (prev_valid),
            .prev_gt    (prev_gt),
            .next_pair  (next_pair),
            .next_valid (next_valid),
            .pair       (cell_pair[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
        );
    end

    // Result formation
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        min_word_next  = min_word_reg;
        min_doc_next   = min_doc_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_OK;
            min_word_next  = '0;
            min_doc_next   = '0;
            if (action == ACT_LOAD)
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
            end
            else if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                min_word_next = cell_pair[0].word;
                min_doc_next  = cell_pair[0].doc;
            end
        end
    end

    // Output valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        min_word_reg <= min_word_next;
        min_doc_reg  <= min_doc_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign min_word  = min_word_reg;
    assign min_doc   = min_doc_reg;

endmodule

[sv/psq_cell.sv]
// One cell of the sorted chain: holds a single pair and its valid bit.
`timescale 1ns / 1ps

module psq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  psq_pkg::cell_cmd_t cmd,
    input  psq_pkg::pair_t    new_pair,
    input  psq_pkg::pair_t    prev_pair,
    input  logic              prev_valid,
    input  logic              prev_gt,
    input  psq_pkg::pair_t    next_pair,
    input  logic              next_valid,
    output psq_pkg::pair_t    pair,
    output logic              valid,
    output logic              gt
);
    import psq_pkg::*;

    pair_t pair_reg;
    pair_t pair_next;
    logic  valid_reg;
    logic  valid_next;

    // New pair goes ahead of this cell's content; an empty cell counts as infinite
    assign gt = !valid_reg || (new_pair < pair_reg);

    // Next content: shift toward head on pull, ordered insert on load
    always_comb
    begin
        pair_next  = pair_reg;
        valid_next = valid_reg;
        if (cmd.pull)
        begin
            pair_next  = next_pair;
            valid_next = next_valid;
        end
        else if (cmd.load)
        begin
            valid_next = valid_reg || prev_valid;
            if (gt)
            begin
                pair_next = prev_gt ? prev_pair : new_pair;
            end
        end
    end

    // Valid bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign pair  = pair_reg;
    assign valid = valid_reg;

endmodule

[sv/psq_checker.sv]
// Port-level checks for the pair sort priority queue, bound to the top level.
`timescale 1ns / 1ps

module psq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [63:0] min_word,
    input logic [63:0] min_doc
);
    import psq_pkg::*;

    // A waiting result is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // Every accepted item yields a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_EMPTY
                       || status == STATUS_FULL))
        else $error("undefined status code");

    // Load results carry zero pair fields and never the empty status
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_LOAD
        |=> status != STATUS_EMPTY && min_word == 64'd0 && min_doc == 64'd0)
        else $error("load result carries pair data");

    // Input ready once the output slot is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

bind pair_sort_priority_queue psq_checker u_psq_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for the pair sort priority queue: random traffic against an in-bench model.
`timescale 1ns / 1ps

module tb;

    import psq_pkg::*;

    localparam int CAPACITY       = 1024;
    localparam int MIXED_ITEMS    = 200;    // transfers before the fill/drain sweep
    localparam int SQUEEZE_AT     = 150;    // transfer count that triggers the long output hold
    localparam int SQUEEZE_CYCLES = 400;
    localparam int QUIET_LIMIT    = 4000;   // cycles with no transfer on either side

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [63:0] word;
    logic [63:0] doc;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [63:0] min_word;
    logic [63:0] min_doc;

    bit calm;           // no idling on either side once set
    bit squeeze_done;

    // Ordered pair store model plus the queue of results still owed by the block
    class pair_order_board;
        typedef struct {
            logic [1:0]  status;
            logic [63:0] word;
            logic [63:0] doc;
        } outcome_t;

        pair_t    held[$];
        outcome_t due[$];
        int       cap;
        int       errors;
        int       loads;
        int       fulls;
        int       pulls;
        int       empties;
        int       checked;
        int       peak;

        function new(int cap_i);
            cap = cap_i;
        endfunction

        function int stored();
            return held.size();
        endfunction

        function int pending();
            return due.size();
        endfunction

        function int transfers();
            return loads + pulls;
        endfunction

        // Apply one accepted item to the model and queue the result it owes
        function void note_transfer(logic act, logic [63:0] w, logic [63:0] d);
            outcome_t o;
            pair_t    p;
            int       best;
            int       i;
            o.status = STATUS_OK;
            o.word   = '0;
            o.doc    = '0;
            if (act == ACT_LOAD)
            begin
                loads++;
                if (held.size() >= cap)
                begin
                    o.status = STATUS_FULL;
                    fulls++;
                end
                else
                begin
                    p.word = w;
                    p.doc  = d;
                    held = {held, p};
                    if (held.size() > peak)
                        peak = held.size();
                end
            end
            else
            begin
                pulls++;
                if (held.size() == 0)
                begin
                    o.status = STATUS_EMPTY;
                    empties++;
                end
                else
                begin
                    // packed compare orders word first, doc second
                    best = 0;
                    for (i = 1; i < held.size(); i++)
                        if (held[i] < held[best])
                            best = i;
                    o.word = held[best].word;
                    o.doc  = held[best].doc;
                    held[best] = held[held.size() - 1];
                    held.delete(held.size() - 1);
                end
            end
            due = {due, o};
        endfunction

        function void compare_field(string name, logic [63:0] exp, logic [63:0] got);
            if (got !== exp)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
            end
        endfunction

        // Compare one result transfer against the oldest owed result
        function void check_result(logic [1:0] st, logic [63:0] w, logic [63:0] d);
            outcome_t o;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d %h %h",
                         $time, st, w, d);
                return;
            end
            o = due.pop_front();
            checked++;
            compare_field("status", 64'(o.status), 64'(st));
            compare_field("min_word", o.word, w);
            compare_field("min_doc", o.doc, d);
        endfunction
    endclass

    pair_order_board board;

    pair_sort_priority_queue #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .word      (word),
        .doc       (doc),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .min_word  (min_word),
        .min_doc   (min_doc)
    );

    // 250 MHz clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Key mix: extremes, near-max values and a small pool so ties show up often
    function automatic logic [63:0] any_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return 64'($urandom_range(0, 7));
            5:       return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one item, optionally after an idle burst, and wait for its transfer
    task automatic push_item(input logic act, input logic [63:0] w, input logic [63:0] d);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        word     <= w;
        doc      <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_transfer(act, w, d);
    endtask

    task automatic random_item(input int load_pct);
        if ($urandom_range(1, 100) <= load_pct)
            push_item(ACT_LOAD, any_key(), any_key());
        else
            push_item(ACT_PULL, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // Stimulus and end of run
    initial
    begin : stimulus
        int seg_len;
        int load_pct;
        board        = new(CAPACITY);
        calm         = 1'b0;
        squeeze_done = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= ACT_LOAD;
        word     <= '0;
        doc      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pull, key extremes, duplicates, doc tie-break, drain past empty
        push_item(ACT_PULL, '1, '1);
        push_item(ACT_LOAD, '0, '0);
        push_item(ACT_LOAD, '1, '1);
        push_item(ACT_LOAD, '1, '0);
        push_item(ACT_LOAD, '0, '1);
        push_item(ACT_LOAD, 64'd5, 64'd7);
        push_item(ACT_LOAD, 64'd5, 64'd7);
        push_item(ACT_LOAD, 64'd5, 64'd3);
        push_item(ACT_LOAD, 64'd4, '1);
        repeat (9) push_item(ACT_PULL, '0, '0);
        push_item(ACT_LOAD, 64'd1, 64'd2);
        push_item(ACT_PULL, '1, '0);
        push_item(ACT_PULL, '0, '1);

        // mixed segments, each biased toward loads, pulls or neither
        while (board.transfers() < MIXED_ITEMS)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       load_pct = 25;
                1:       load_pct = 50;
                default: load_pct = 80;
            endcase
            repeat (seg_len) random_item(load_pct);
        end

        // fill to capacity, then loads that must be refused
        while (board.stored() < CAPACITY)
            push_item(ACT_LOAD, any_key(), any_key());
        repeat (6) push_item(ACT_LOAD, any_key(), any_key());

        // drain in sorted order; the tail runs with no idling
        while (board.stored() > 0)
        begin
            if (board.stored() < 200)
                calm = 1'b1;
            push_item(ACT_PULL, {$urandom, $urandom}, {$urandom, $urandom});
        end
        repeat (4) push_item(ACT_PULL, {$urandom, $urandom}, {$urandom, $urandom});
        in_valid <= 1'b0;

        while (board.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("tb: %0d loads (%0d refused on a full store), %0d pulls (%0d on an empty store)",
                 board.loads, board.fulls, board.pulls, board.empties);
        $display("tb: %0d results compared, peak fill %0d of %0d, %0d mismatches",
                 board.checked, board.peak, CAPACITY, board.errors);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: check each transfer, stall in random bursts plus one long hold
    initial
    begin : result_side
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(status, min_word, min_doc);
            if (!squeeze_done && board.transfers() >= SQUEEZE_AT)
            begin
                squeeze_done = 1'b1;
                hold = SQUEEZE_CYCLES;
            end
            else if (hold == 0 && !calm && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 11);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: too long without a transfer on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: no transfer for %0d cycles at %0t", quiet, $time);
        $display("tb: failure");
        $finish;
    end

endmodule
